[hw/rtl/rmf_pkg.sv]
// package for the running median filter: payload structs, command and
// status structs shared by the controller, datapath and top level
// no dependencies
`timescale 1ns / 1ps

package rmf_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int CFG_WIDTH    = 6;
    localparam logic [CFG_WIDTH-1:0] WIN_LEN_RESET = 6'd5;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] sample_value;
        logic                    sample_last;
    } t_sample;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] median_value;
        logic                    result_last;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic cap;       // capture the incoming sample
        logic del;       // remove the oldest sample from the sorted cells
        logic ins;       // insert the captured sample, update the window store
        logic shift;     // window store shifts instead of growing
        logic med;       // register the selected sorted entry
        logic out_load;  // load one result into the output register
        logic out_last;  // the loaded result ends the series
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

[hw/rtl/rmf_dpath.sv]
// datapath of the running median filter: window store, sorted cells,
// median register and output register
// depends on rmf_pkg
`timescale 1ns / 1ps

module rmf_dpath
    import rmf_pkg::*;
#(
    parameter int MAX_WINDOW = 32,
    parameter int CW = $clog2(MAX_WINDOW + 1),
    parameter int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [CW-1:0] i_win,
    input  logic [CW-1:0] i_fill,
    input  logic [CW-1:0] i_ins_n,
    input  logic [IW-1:0] i_med_idx,
    input  t_sample       i_in_data,
    input  logic          i_out_stall,
    output t_status       o_status,
    output logic          o_out_valid,
    output t_result       o_out_data
);

    logic [SAMPLE_WIDTH-1:0] r_store  [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] r_sorted [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] n_store  [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] n_sorted [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic [SAMPLE_WIDTH-1:0] r_median;
    logic                    r_out_valid;
    t_result                 r_out_data;
    logic [MAX_WINDOW-1:0]   w_le;
    logic [MAX_WINDOW-1:0]   w_ge;
    logic                    w_out_free;

    // per-cell compares against the new sample and the oldest sample
    always_comb begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
            w_le[k] = (CW'(k) < i_ins_n) && (r_sorted[k] <= r_sample);
            w_ge[k] = (r_sorted[k] >= r_store[0]);
        end
    end

    // sorted cells: delete shifts down, insert shifts up past the slot
    always_comb begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
            n_sorted[k] = r_sorted[k];
            if (i_cmd.del) begin
                if (w_ge[k] && (k < MAX_WINDOW - 1)) begin
                    n_sorted[k] = r_sorted[(k + 1) % MAX_WINDOW];
                end
            end else if (i_cmd.ins) begin
                if (!w_le[k]) begin
                    if (k == 0) begin
                        n_sorted[k] = r_sample;
                    end else if (w_le[(k + MAX_WINDOW - 1) % MAX_WINDOW]) begin
                        n_sorted[k] = r_sample;
                    end else begin
                        n_sorted[k] = r_sorted[(k + MAX_WINDOW - 1) % MAX_WINDOW];
                    end
                end
            end
        end
    end

    // window store, oldest first: grows at the fill point or shifts by one
    always_comb begin
        for (int k = 0; k < MAX_WINDOW; k++) begin
            n_store[k] = r_store[k];
            if (i_cmd.ins) begin
                if (i_cmd.shift) begin
                    if (CW'(k + 1) < i_win) begin
                        n_store[k] = r_store[(k + 1) % MAX_WINDOW];
                    end else if (CW'(k + 1) == i_win) begin
                        n_store[k] = r_sample;
                    end
                end else if (CW'(k) == i_fill) begin
                    n_store[k] = r_sample;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_store  <= n_store;
        r_sorted <= n_sorted;
        if (i_cmd.cap) begin
            r_sample <= i_in_data.sample_value;
        end
        if (i_cmd.med) begin
            r_median <= r_sorted[i_med_idx];
        end
        if (i_cmd.out_load) begin
            r_out_data.median_value <= r_median;
            r_out_data.result_last  <= i_cmd.out_last;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign w_out_free        = !r_out_valid || !i_out_stall;
    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

[hw/rtl/rmf_ctrl.sv]
// controller of the running median filter: sequencer, window length
// register, fill count and result copy counter
// depends on rmf_pkg
`timescale 1ns / 1ps

module rmf_ctrl
    import rmf_pkg::*;
#(
    parameter int MAX_WINDOW = 32,
    parameter int CW = $clog2(MAX_WINDOW + 1),
    parameter int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    output logic                 o_in_stall,
    input  logic                 i_cfg_valid,
    input  logic [CFG_WIDTH-1:0] i_cfg_data,
    output logic                 o_cfg_ready,
    input  t_status              i_status,
    output t_cmd                 o_cmd,
    output logic [CW-1:0]        o_win,
    output logic [CW-1:0]        o_fill,
    output logic [CW-1:0]        o_ins_n,
    output logic [IW-1:0]        o_med_idx
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL,
        S_INS,
        S_MED,
        S_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_WIDTH-1:0] r_win_len, n_win_len;
    logic [CW-1:0]        r_fill, n_fill;
    logic [CW-1:0]        r_copies, n_copies;
    logic                 r_last, n_last;
    logic [CW-1:0]        w_win;
    logic [CW-1:0]        w_half;
    logic                 w_full;
    logic [CW-1:0]        w_fill_nx;
    logic                 w_accept;
    logic                 w_cfg_wr;

    // effective window: zero acts as one, oversize clamps to the store depth
    always_comb begin
        if (r_win_len == '0) begin
            w_win = CW'(1);
        end else if (int'(r_win_len) > MAX_WINDOW) begin
            w_win = CW'(MAX_WINDOW);
        end else begin
            w_win = CW'(r_win_len);
        end
    end

    // a pending window write goes first, the sample request waits while it is pending
    assign w_half    = w_win >> 1;
    assign w_full    = (r_fill == w_win);
    assign w_fill_nx = w_full ? r_fill : r_fill + CW'(1);
    assign w_accept  = (r_state == S_IDLE) && i_in_valid && !i_cfg_valid;
    assign w_cfg_wr  = (r_state == S_IDLE) && i_cfg_valid;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_win_len = r_win_len;
        n_fill    = r_fill;
        n_copies  = r_copies;
        n_last    = r_last;
        o_cmd     = '0;
        o_ins_n   = w_full ? (w_win - CW'(1)) : r_fill;
        o_med_idx = w_full ? IW'(w_half) : IW'(r_fill >> 1);
        case (r_state)
            S_IDLE: begin
                if (w_cfg_wr) begin
                    n_win_len = i_cfg_data;
                    n_fill    = '0;
                end
                if (w_accept) begin
                    o_cmd.cap = 1'b1;
                    n_last    = i_in_last;
                    n_state   = w_full ? S_DEL : S_INS;
                end
            end
            S_DEL: begin
                o_cmd.del = 1'b1;
                n_state   = S_INS;
            end
            S_INS: begin
                o_cmd.ins   = 1'b1;
                o_cmd.shift = w_full;
                n_fill      = w_fill_nx;
                if (w_fill_nx == w_win) begin
                    n_copies = (w_full ? CW'(1) : (w_win - w_half))
                             + (r_last ? w_half : '0);
                    n_state  = S_MED;
                end else if (r_last) begin
                    n_copies = w_fill_nx;
                    n_state  = S_MED;
                end else begin
                    n_state  = S_IDLE;
                end
            end
            S_MED: begin
                o_cmd.med = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = r_last && (r_copies == CW'(1));
                    n_copies       = r_copies - CW'(1);
                    if (r_copies == CW'(1)) begin
                        n_state = S_IDLE;
                        if (r_last) begin
                            n_fill = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_win_len <= WIN_LEN_RESET;
            r_fill    <= '0;
            r_copies  <= '0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_win_len <= n_win_len;
            r_fill    <= n_fill;
            r_copies  <= n_copies;
            r_last    <= n_last;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_win       = w_win;
    assign o_fill      = r_fill;

    // the window never holds more samples than its length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_win)
        else $error("fill count above window length");

    // emitting always has a copy left to send
    a_emit_copies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_copies != '0))
        else $error("emit state with no copies left");

    // an accepted sample into a partial window goes straight to insert
    a_grow_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full) |=> (r_state == S_INS))
        else $error("partial window did not insert directly");

    // removal of the oldest sample is always followed by the insert
    a_del_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) |=> (r_state == S_INS && r_fill == w_win))
        else $error("delete not followed by insert on a full window");

endmodule

[hw/rtl/running_median_filter.sv]
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    i_in_data  (t_sample)
// out       output     o_out_valid / i_out_stall  o_out_data (t_result)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (window length)
//
// a sample into a partial window is captured, then inserted; one into a full window
// is captured, then passes delete oldest and insert newest through the sorted cells
// a sample that produces results adds a median step and one output load per copy;
// a full-window sample emits one copy (plus half the window on the last one), the filling one up to W
// i_rst_n is synchronous active low; window length returns to 5, series dropped
// output stalls hold the copy sequence; input stalls until it ends or a window write waits
//
// top level of the running median filter; depends on rmf_pkg, rmf_ctrl, rmf_dpath
`timescale 1ns / 1ps

module running_median_filter
    import rmf_pkg::*;
#(
    parameter int MAX_WINDOW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_sample              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_result              o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_WIDTH-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    t_cmd          w_cmd;
    t_status       w_status;
    logic [CW-1:0] w_win;
    logic [CW-1:0] w_fill;
    logic [CW-1:0] w_ins_n;
    logic [IW-1:0] w_med_idx;

    // sequencer
    rmf_ctrl #(
        .MAX_WINDOW (MAX_WINDOW),
        .CW         (CW),
        .IW         (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.sample_last),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_win       (w_win),
        .o_fill      (w_fill),
        .o_ins_n     (w_ins_n),
        .o_med_idx   (w_med_idx)
    );

    // window, sorted cells and output register
    rmf_dpath #(
        .MAX_WINDOW (MAX_WINDOW),
        .CW         (CW),
        .IW         (IW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_win       (w_win),
        .i_fill      (w_fill),
        .i_ins_n     (w_ins_n),
        .i_med_idx   (w_med_idx),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
